FILE: rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg - shared types and constants of the MIDI track event parser
// Event record passed from the byte parser to the result stage, parse phase
// and event kind codes, MIDI status codes and default sizes.
// ----------------------------------------------------------------------------
package mtep_pkg;

  // default sizes of the internal counters
  localparam int TICK_BITS_DEF     = 32;
  localparam int LENGTH_BITS_DEF   = 28;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int DIVISION_W = 15;
  localparam int TEMPO_W    = 24;
  localparam int TEMPO10_W  = 28;  // width of tempo * 10
  localparam int TICK_W     = 32;
  localparam int PERIOD_W   = 44;

  // event queue between parser and result stage
  localparam int QUEUE_DEPTH = 2;

  // reset value of the time division register
  localparam logic [DIVISION_W-1:0] DIVISION_RESET = 15'd96;

  // status and meta codes
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_EOT     = 8'h2F;

  typedef enum logic [2:0] {
    KIND_CHANNEL   = 3'd0,
    KIND_TEMPO     = 3'd1,
    KIND_END_TRACK = 3'd2,
    KIND_META      = 3'd3,
    KIND_SYSEX     = 3'd4,
    KIND_SYSTEM    = 3'd5,
    KIND_TRUNCATED = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    PH_DELTA,
    PH_DELTA_MORE,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_META_TYPE,
    PH_META_LEN,
    PH_META_BODY,
    PH_SYSEX_LEN,
    PH_SYSEX_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic {
    BK_IDLE,
    BK_DIVIDE
  } back_state_t;

  // one decoded event, everything but the tick period
  typedef struct packed {
    kind_t               kind;
    logic [7:0]          status;
    logic [7:0]          first;
    logic [7:0]          second;
    logic [7:0]          meta;
    logic [TICK_W-1:0]   tick;
    logic [TEMPO_W-1:0]  tempo;
  } event_t;

endpackage

FILE: rtl/midi_track_event_parser_core.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser_core - MIDI track chunk event parser
// Parses a track chunk byte stream into events with absolute ticks, and the
// tick period of tempo events.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  data_byte, chunk_end
//   out      output     out_valid/out_stall  event_kind .. tick_period
//   cfg      input      cfg_write            cfg_data (time division)
//
// One input byte is taken per cycle while the event queue has room.
// Events other than tempo are loaded into the output register from the
// queue head once the output is free. A tempo event holds the result stage
// while the one-bit-per-cycle divider works out its tick period.
// Reset is synchronous; the parser state also restarts after a chunk_end byte.
// in_stall is high while the event queue is full; a stalled output holds.
// ----------------------------------------------------------------------------
module midi_track_event_parser_core #(
  parameter int TICK_BITS     = mtep_pkg::TICK_BITS_DEF,
  parameter int LENGTH_BITS   = mtep_pkg::LENGTH_BITS_DEF,
  parameter int FRACTION_BITS = mtep_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mtep_pkg::DIVISION_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            chunk_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      event_kind,
  output logic [7:0]                      status_byte,
  output logic [7:0]                      first_data,
  output logic [7:0]                      second_data,
  output logic [7:0]                      meta_kind,
  output logic [mtep_pkg::TICK_W-1:0]     event_tick,
  output logic [mtep_pkg::TEMPO_W-1:0]    tempo_value,
  output logic [mtep_pkg::PERIOD_W-1:0]   tick_period
);
  import mtep_pkg::*;

  logic   in_accept;
  logic   ev_valid;
  event_t ev;
  logic   q_full;
  logic   q_not_empty;
  logic   q_pop;
  event_t q_head;

  // take a byte whenever the queue can hold its event
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  mtep_front #(
    .TICK_BITS   (TICK_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .data_byte (data_byte),
    .chunk_end (chunk_end),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  mtep_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept && ev_valid),
    .push_ev   (ev),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_ev   (q_head)
  );

  mtep_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_kind  (event_kind),
    .status_byte (status_byte),
    .first_data  (first_data),
    .second_data (second_data),
    .meta_kind   (meta_kind),
    .event_tick  (event_tick),
    .tempo_value (tempo_value),
    .tick_period (tick_period)
  );

endmodule

FILE: rtl/mtep_front.sv
// ----------------------------------------------------------------------------
// mtep_front - byte parser
// Walks the track chunk one byte per transfer: delta times, running status,
// channel data, meta and sysex lengths and payloads. Emits one event record
// for each completed event, or a truncation record at a premature chunk end.
// ----------------------------------------------------------------------------
module mtep_front #(
  parameter int TICK_BITS   = mtep_pkg::TICK_BITS_DEF,
  parameter int LENGTH_BITS = mtep_pkg::LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             chunk_end,
  output logic             ev_valid,
  output mtep_pkg::event_t ev
);
  import mtep_pkg::*;

  phase_t                 phase, phase_next;
  logic [7:0]             running_status, running_status_next;
  logic [LENGTH_BITS-1:0] delta_acc, delta_acc_next;
  logic [TICK_BITS-1:0]   abs_tick, abs_tick_next;
  logic [7:0]             held_first, held_first_next;
  logic [7:0]             held_meta, held_meta_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic [TEMPO_W-1:0]     tempo_acc, tempo_acc_next;
  logic [1:0]             pidx, pidx_next;

  logic [LENGTH_BITS-1:0] delta_base;
  logic [LENGTH_BITS-1:0] delta_vlq;
  logic [LENGTH_BITS-1:0] length_vlq;
  logic [LENGTH_BITS-1:0] remaining_dec;
  logic [7:0]             trunc_status;

  // status C0-DF carries a single data byte
  function automatic logic one_data(input logic [7:0] st);
    return st[7:5] == 3'b110;
  endfunction

  function automatic event_t make_event(input kind_t k, input logic [7:0] st,
                                        input logic [7:0] d1, input logic [7:0] d2,
                                        input logic [7:0] mk,
                                        input logic [TEMPO_W-1:0] tp);
    event_t e;
    e.kind   = k;
    e.status = st;
    e.first  = d1;
    e.second = d2;
    e.meta   = mk;
    e.tick   = '0;
    e.tempo  = tp;
    return e;
  endfunction

  assign delta_base    = (phase == PH_DELTA) ? '0 : delta_acc;
  assign delta_vlq     = {delta_base[LENGTH_BITS-8:0], data_byte[6:0]};
  assign length_vlq    = {remaining[LENGTH_BITS-8:0], data_byte[6:0]};
  assign remaining_dec = remaining - LENGTH_BITS'(1);

  // next state and event for the byte on the input
  always_comb begin
    phase_next          = phase;
    running_status_next = running_status;
    delta_acc_next      = delta_acc;
    abs_tick_next       = abs_tick;
    held_first_next     = held_first;
    held_meta_next      = held_meta;
    remaining_next      = remaining;
    tempo_acc_next      = tempo_acc;
    pidx_next           = pidx;
    ev_valid            = 1'b0;
    ev                  = make_event(KIND_CHANNEL, 8'h00, 8'h00, 8'h00, 8'h00, '0);
    trunc_status        = 8'h00;

    unique case (phase)
      PH_DELTA, PH_DELTA_MORE: begin
        if (data_byte[7]) begin
          delta_acc_next = delta_vlq;
          phase_next     = PH_DELTA_MORE;
        end else begin
          abs_tick_next  = abs_tick + TICK_BITS'(delta_vlq);
          delta_acc_next = '0;
          phase_next     = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (!data_byte[7]) begin
          // data byte: reuse running status
          if (one_data(running_status)) begin
            ev_valid   = 1'b1;
            ev         = make_event(KIND_CHANNEL, running_status, data_byte, 8'h00,
                                    8'h00, '0);
            phase_next = PH_DELTA;
          end else begin
            held_first_next = data_byte;
            phase_next      = PH_DATA2;
          end
        end else if (data_byte[7:4] != 4'hF) begin
          running_status_next = data_byte;
          phase_next          = PH_DATA1;
        end else begin
          running_status_next = 8'h00;
          if (data_byte == ST_META) begin
            phase_next = PH_META_TYPE;
          end else if (data_byte == ST_SYSEX || data_byte == ST_SYSEX_ESC) begin
            held_first_next = data_byte;
            remaining_next  = '0;
            phase_next      = PH_SYSEX_LEN;
          end else begin
            ev_valid   = 1'b1;
            ev         = make_event(KIND_SYSTEM, data_byte, 8'h00, 8'h00, 8'h00, '0);
            phase_next = PH_DELTA;
          end
        end
      end
      PH_DATA1: begin
        if (one_data(running_status)) begin
          ev_valid   = 1'b1;
          ev         = make_event(KIND_CHANNEL, running_status, data_byte, 8'h00,
                                  8'h00, '0);
          phase_next = PH_DELTA;
        end else begin
          held_first_next = data_byte;
          phase_next      = PH_DATA2;
        end
      end
      PH_DATA2: begin
        ev_valid   = 1'b1;
        ev         = make_event(KIND_CHANNEL, running_status, held_first, data_byte,
                                8'h00, '0);
        phase_next = PH_DELTA;
      end
      PH_META_TYPE: begin
        held_meta_next = data_byte;
        remaining_next = '0;
        tempo_acc_next = '0;
        pidx_next      = 2'd0;
        phase_next     = PH_META_LEN;
      end
      PH_META_LEN, PH_SYSEX_LEN, PH_META_BODY, PH_SYSEX_BODY: begin
        if (phase == PH_META_LEN || phase == PH_SYSEX_LEN) begin
          remaining_next = length_vlq;
        end else begin
          remaining_next = remaining_dec;
        end
        // collect up to three tempo bytes, high byte first
        if (phase == PH_META_BODY && held_meta == META_TEMPO && pidx != 2'd3) begin
          case (pidx)
            2'd0:    tempo_acc_next[23:16] = tempo_acc[23:16] | data_byte;
            2'd1:    tempo_acc_next[15:8]  = tempo_acc[15:8] | data_byte;
            default: tempo_acc_next[7:0]   = tempo_acc[7:0] | data_byte;
          endcase
          pidx_next = pidx + 2'd1;
        end
        if ((phase == PH_META_LEN || phase == PH_SYSEX_LEN) && data_byte[7]) begin
          // more length bytes follow
        end else if (remaining_next == '0) begin
          ev_valid = 1'b1;
          if (phase == PH_SYSEX_LEN || phase == PH_SYSEX_BODY) begin
            ev         = make_event(KIND_SYSEX, held_first, 8'h00, 8'h00, 8'h00, '0);
            phase_next = PH_DELTA;
          end else if (held_meta == META_TEMPO) begin
            ev         = make_event(KIND_TEMPO, ST_META, 8'h00, 8'h00, held_meta,
                                    tempo_acc_next);
            phase_next = PH_DELTA;
          end else if (held_meta == META_EOT) begin
            ev         = make_event(KIND_END_TRACK, ST_META, 8'h00, 8'h00, held_meta, '0);
            phase_next = PH_DONE;
          end else begin
            ev         = make_event(KIND_META, ST_META, 8'h00, 8'h00, held_meta, '0);
            phase_next = PH_DELTA;
          end
        end else if (phase == PH_META_LEN) begin
          phase_next = PH_META_BODY;
        end else if (phase == PH_SYSEX_LEN) begin
          phase_next = PH_SYSEX_BODY;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
    endcase

    // chunk end: flag an unfinished event, then start over
    if (chunk_end) begin
      if (phase_next == PH_META_TYPE || phase_next == PH_META_LEN ||
          phase_next == PH_META_BODY) begin
        trunc_status = ST_META;
      end else if (phase_next == PH_SYSEX_LEN || phase_next == PH_SYSEX_BODY) begin
        trunc_status = held_first_next;
      end else begin
        trunc_status = running_status_next;
      end
      if (!ev_valid && phase_next != PH_DELTA && phase_next != PH_DONE) begin
        ev_valid = 1'b1;
        ev       = make_event(KIND_TRUNCATED, trunc_status, 8'h00, 8'h00, 8'h00, '0);
      end
    end
    ev.tick = TICK_W'(abs_tick_next);
  end

  // advance the parse state on each transfer
  always_ff @(posedge clk) begin
    if (rst || (accept && chunk_end)) begin
      phase          <= PH_DELTA;
      running_status <= 8'h00;
      delta_acc      <= '0;
      abs_tick       <= '0;
      held_first     <= 8'h00;
      held_meta      <= 8'h00;
      remaining      <= '0;
      tempo_acc      <= '0;
      pidx           <= 2'd0;
    end else if (accept) begin
      phase          <= phase_next;
      running_status <= running_status_next;
      delta_acc      <= delta_acc_next;
      abs_tick       <= abs_tick_next;
      held_first     <= held_first_next;
      held_meta      <= held_meta_next;
      remaining      <= remaining_next;
      tempo_acc      <= tempo_acc_next;
      pidx           <= pidx_next;
    end
  end

endmodule

FILE: rtl/mtep_queue.sv
// ----------------------------------------------------------------------------
// mtep_queue - event queue
// Short first-in first-out buffer of event records between the byte parser
// and the result stage, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module mtep_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mtep_pkg::event_t push_ev,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output mtep_pkg::event_t head_ev
);
  import mtep_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  event_t          entries [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_ev   = entries[rd_ptr];

  // store pushed records
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_ev;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/mtep_divider.sv
// ----------------------------------------------------------------------------
// mtep_divider - restoring divider
// Divides the scaled tempo by the time division, one quotient bit per cycle.
// Raises done for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module mtep_divider #(
  parameter int QUOT_BITS = mtep_pkg::TEMPO10_W + mtep_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [QUOT_BITS-1:0]            dividend,
  input  logic [mtep_pkg::DIVISION_W-1:0] divisor,
  output logic                            done,
  output logic [QUOT_BITS-1:0]            quotient
);
  import mtep_pkg::*;

  localparam int CNT_W = $clog2(QUOT_BITS + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISION_W-1:0] rem;
  logic [DIVISION_W-1:0] dsr;
  logic [DIVISION_W:0]   trial;
  logic                  fits;

  assign trial = {rem, quotient[QUOT_BITS-1]};
  assign fits  = (trial >= {1'b0, dsr});

  // shift dividend bits out and quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= fits ? DIVISION_W'(trial - {1'b0, dsr}) : trial[DIVISION_W-1:0];
      quotient <= {quotient[QUOT_BITS-2:0], fits};
    end
  end

  // count steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(QUOT_BITS);
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/mtep_back.sv
// ----------------------------------------------------------------------------
// mtep_back - result stage
// Takes event records from the queue, works out the tick period of tempo
// events through the divider and holds each result in the output register.
// Also keeps the time division register.
// ----------------------------------------------------------------------------
module mtep_back #(
  parameter int FRACTION_BITS = mtep_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mtep_pkg::DIVISION_W-1:0] cfg_data,
  input  logic                            q_not_empty,
  input  mtep_pkg::event_t                q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      event_kind,
  output logic [7:0]                      status_byte,
  output logic [7:0]                      first_data,
  output logic [7:0]                      second_data,
  output logic [7:0]                      meta_kind,
  output logic [mtep_pkg::TICK_W-1:0]     event_tick,
  output logic [mtep_pkg::TEMPO_W-1:0]    tempo_value,
  output logic [mtep_pkg::PERIOD_W-1:0]   tick_period
);
  import mtep_pkg::*;

  localparam int QUOT_BITS = TEMPO10_W + FRACTION_BITS;

  back_state_t           state, state_next;
  logic [DIVISION_W-1:0] time_division;
  event_t                held_ev;
  logic                  out_free;
  logic                  div_start;
  logic                  div_done;
  logic                  load_direct;
  logic                  load_tempo;
  logic [TEMPO10_W-1:0]  tempo_x10;
  logic [QUOT_BITS-1:0]  dividend;
  logic [DIVISION_W-1:0] divisor;
  logic [QUOT_BITS-1:0]  quotient;
  logic [QUOT_BITS-1:0]  period_full;

  // time division register
  always_ff @(posedge clk) begin
    if (rst) begin
      time_division <= DIVISION_RESET;
    end else if (cfg_write) begin
      time_division <= cfg_data;
    end
  end

  // tempo * 10 as shift and add, scaled to the fixed point
  assign tempo_x10 = TEMPO10_W'({q_head.tempo, 3'b000}) + TEMPO10_W'({q_head.tempo, 1'b0});
  assign dividend  = {tempo_x10, {FRACTION_BITS{1'b0}}};
  assign divisor   = (time_division == '0) ? DIVISION_W'(1) : time_division;

  mtep_divider #(
    .QUOT_BITS (QUOT_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // clamp the period at one
  assign period_full = (quotient < (QUOT_BITS'(1) << FRACTION_BITS)) ?
                       (QUOT_BITS'(1) << FRACTION_BITS) : quotient;

  assign out_free = !out_valid || !out_stall;

  // take records and start divisions
  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    div_start   = 1'b0;
    load_direct = 1'b0;
    load_tempo  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_not_empty && out_free) begin
          q_pop = 1'b1;
          if (q_head.kind == KIND_TEMPO) begin
            div_start  = 1'b1;
            state_next = BK_DIVIDE;
          end else begin
            load_direct = 1'b1;
          end
        end
      end
      BK_DIVIDE: begin
        if (div_done) begin
          load_tempo = 1'b1;
          state_next = BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the tempo record while dividing
  always_ff @(posedge clk) begin
    if (div_start) begin
      held_ev <= q_head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_direct || load_tempo) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      event_kind  <= q_head.kind;
      status_byte <= q_head.status;
      first_data  <= q_head.first;
      second_data <= q_head.second;
      meta_kind   <= q_head.meta;
      event_tick  <= q_head.tick;
      tempo_value <= q_head.tempo;
      tick_period <= '0;
    end else if (load_tempo) begin
      event_kind  <= held_ev.kind;
      status_byte <= held_ev.status;
      first_data  <= held_ev.first;
      second_data <= held_ev.second;
      meta_kind   <= held_ev.meta;
      event_tick  <= held_ev.tick;
      tempo_value <= held_ev.tempo;
      tick_period <= PERIOD_W'(period_full);
    end
  end

endmodule
